>>> src/aaru_pkg.sv
// types and command codes shared by the accumulator alu register unit
package aaru_pkg;

  localparam int unsigned CmdW  = 5;
  localparam int unsigned DataW = 8;

  typedef enum logic [CmdW-1:0] {
    CMD_ADC = 5'd0,
    CMD_SBC = 5'd1,
    CMD_AND = 5'd2,
    CMD_EOR = 5'd3,
    CMD_ORA = 5'd4,
    CMD_ROL = 5'd5,
    CMD_ROR = 5'd6,
    CMD_SEC = 5'd7,
    CMD_CLC = 5'd8,
    CMD_SED = 5'd9,
    CMD_CLD = 5'd10,
    CMD_SEI = 5'd11,
    CMD_CLI = 5'd12,
    CMD_TAX = 5'd13,
    CMD_TAY = 5'd14,
    CMD_TXA = 5'd15,
    CMD_TYA = 5'd16,
    CMD_TSX = 5'd17,
    CMD_TXS = 5'd18
  } cmd_t;

  // architectural registers and status flags
  typedef struct packed {
    logic [DataW-1:0] acc;
    logic [DataW-1:0] x;
    logic [DataW-1:0] y;
    logic [DataW-1:0] sp;
    logic             n;
    logic             z;
    logic             c;
    logic             v;
    logic             d;
    logic             i;
  } arch_t;

endpackage

>>> src/aaru_alu.sv
// execution logic: next register and flag state for one command
module aaru_alu
  import aaru_pkg::*;
(
  input  arch_t            cur,
  input  logic [CmdW-1:0]  command,
  input  logic [DataW-1:0] operand,
  output arch_t            nxt
);

  logic [DataW-1:0] add_m;
  logic [DataW:0]   sum;
  logic [DataW-1:0] res;
  logic             add_v;

  // sbc is adc with the inverted operand
  assign add_m = (command == CMD_SBC) ? ~operand : operand;
  assign sum   = {1'b0, cur.acc} + {1'b0, add_m} + {{DataW{1'b0}}, cur.c};
  assign add_v = ~(cur.acc[DataW-1] ^ add_m[DataW-1]) & (cur.acc[DataW-1] ^ sum[DataW-1]);

  always_comb begin
    nxt = cur;
    res = '0;
    case (command)
      CMD_ADC, CMD_SBC: begin
        res     = sum[DataW-1:0];
        nxt.acc = res;
        nxt.c   = sum[DataW];
        nxt.v   = add_v;
      end
      CMD_AND: begin
        res     = cur.acc & operand;
        nxt.acc = res;
      end
      CMD_EOR: begin
        res     = cur.acc ^ operand;
        nxt.acc = res;
      end
      CMD_ORA: begin
        res     = cur.acc | operand;
        nxt.acc = res;
      end
      CMD_ROL: begin
        res     = {cur.acc[DataW-2:0], cur.c};
        nxt.acc = res;
        nxt.c   = cur.acc[DataW-1];
      end
      CMD_ROR: begin
        res     = {cur.c, cur.acc[DataW-1:1]};
        nxt.acc = res;
        nxt.c   = cur.acc[0];
      end
      CMD_SEC: nxt.c = 1'b1;
      CMD_CLC: nxt.c = 1'b0;
      CMD_SED: nxt.d = 1'b1;
      CMD_CLD: nxt.d = 1'b0;
      CMD_SEI: nxt.i = 1'b1;
      CMD_CLI: nxt.i = 1'b0;
      CMD_TAX: begin
        res   = cur.acc;
        nxt.x = res;
      end
      CMD_TAY: begin
        res   = cur.acc;
        nxt.y = res;
      end
      CMD_TXA: begin
        res     = cur.x;
        nxt.acc = res;
      end
      CMD_TYA: begin
        res     = cur.y;
        nxt.acc = res;
      end
      CMD_TSX: begin
        res   = cur.sp;
        nxt.x = res;
      end
      CMD_TXS: nxt.sp = cur.x;
      default: ;
    endcase

    // n and z follow the result of every command that produces one
    case (command)
      CMD_ADC, CMD_SBC, CMD_AND, CMD_EOR, CMD_ORA, CMD_ROL, CMD_ROR,
      CMD_TAX, CMD_TAY, CMD_TXA, CMD_TYA, CMD_TSX: begin
        nxt.n = res[DataW-1];
        nxt.z = (res == '0);
      end
      default: ;
    endcase
  end

endmodule

>>> src/accumulator_alu_register_unit.sv
// top level of the accumulator alu register unit
// An 8-bit accumulator execution unit. Each input beat carries a command and
// an operand byte; the unit applies it to A, X, Y, SP and the N, Z, C, V, D, I
// flags and returns one output beat holding every register and flag after the
// command. Arithmetic is binary only, D is stored and reported. Unused command
// codes leave the state unchanged and still return a beat. An input beat is
// captured in an input register, the alu computes the new state from it, and the
// state is written into the architectural registers that also drive the output
// ports, with out_valid raised as the command retires. The unit sustains one
// command per cycle while the output is taken; a stalled output holds the input
// register, and the input stays ready while a slot is free. Reset clears the valid
// flags and the architectural registers; the input payload register is not reset.
module accumulator_alu_register_unit
  import aaru_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CmdW-1:0]  in_command,
  input  logic [DataW-1:0] in_operand,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [DataW-1:0] out_acc_out,
  output logic [DataW-1:0] out_x_out,
  output logic [DataW-1:0] out_y_out,
  output logic [DataW-1:0] out_sp_out,
  output logic             out_neg_flag,
  output logic             out_zero_flag,
  output logic             out_carry_flag,
  output logic             out_ovf_flag,
  output logic             out_dec_flag,
  output logic             out_irq_mask_flag
);

  // input register stage
  logic             s1_valid_r;
  logic [CmdW-1:0]  s1_cmd_r;
  logic [DataW-1:0] s1_opnd_r;

  // architectural state doubles as the output payload register
  arch_t            arch_r;
  arch_t            arch_nxt;
  logic             out_valid_r;

  logic             out_free;
  logic             s1_adv;

  // output slot can take a new beat when empty or being drained
  assign out_free = ~out_valid_r | out_ready;
  assign s1_adv   = s1_valid_r & out_free;
  assign in_ready = ~s1_valid_r | s1_adv;

  aaru_alu u_alu (
    .cur     (arch_r),
    .command (s1_cmd_r),
    .operand (s1_opnd_r),
    .nxt     (arch_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  // payload of the input register needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd_r  <= in_command;
      s1_opnd_r <= in_operand;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      arch_r      <= '0;
    end else begin
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
      // state moves only when a command retires into the output slot
      if (s1_adv) begin
        arch_r <= arch_nxt;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_acc_out       = arch_r.acc;
  assign out_x_out         = arch_r.x;
  assign out_y_out         = arch_r.y;
  assign out_sp_out        = arch_r.sp;
  assign out_neg_flag      = arch_r.n;
  assign out_zero_flag     = arch_r.z;
  assign out_carry_flag    = arch_r.c;
  assign out_ovf_flag      = arch_r.v;
  assign out_dec_flag      = arch_r.d;
  assign out_irq_mask_flag = arch_r.i;

  // a held input beat survives an output stall
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_free |=> s1_valid_r && $stable(s1_cmd_r) && $stable(s1_opnd_r))
    else $error("input register lost its beat during a stall");

  // state changes only when a command retires
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(arch_r))
    else $error("architectural state changed without a retiring command");

  // a drained output with nothing behind it goes empty
  a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ready && !s1_valid_r |=> !out_valid_r)
    else $error("output beat repeated after being taken");

endmodule

>>> tb/tb.sv
// testbench for the accumulator alu register unit with predictor and result checker
`timescale 1ns / 100ps

module tb
  import aaru_pkg::*;
();

  // cycles with no beat on either side before the run is called hung
  localparam int unsigned StallLimit  = 2000;
  // cycles to keep watching the output once nothing is outstanding
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned RandomItems = 600;
  localparam int unsigned MaxGap      = 12;

  // command codes the unit does not decode, both ends of the unused range
  localparam logic [CmdW-1:0] CMD_UNUSED_LO = CmdW'(CMD_TXS + 1);
  localparam logic [CmdW-1:0] CMD_UNUSED_HI = '1;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [CmdW-1:0]  in_command;
  logic [DataW-1:0] in_operand;
  logic             out_valid;
  logic             out_ready;
  logic [DataW-1:0] out_acc_out;
  logic [DataW-1:0] out_x_out;
  logic [DataW-1:0] out_y_out;
  logic [DataW-1:0] out_sp_out;
  logic             out_neg_flag;
  logic             out_zero_flag;
  logic             out_carry_flag;
  logic             out_ovf_flag;
  logic             out_dec_flag;
  logic             out_irq_mask_flag;

  // predicted register file and the register snapshots still owed by the unit
  arch_t cpu_state;
  arch_t pending_snapshots[$];

  int unsigned error_count;
  int unsigned quiet_cycles;

  // idle control shared between the stimulus and the result sink
  bit          tx_no_idle;
  bit          rx_no_idle;
  int unsigned rx_hold_cycles;

  accumulator_alu_register_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_operand       (in_operand),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_acc_out      (out_acc_out),
    .out_x_out        (out_x_out),
    .out_y_out        (out_y_out),
    .out_sp_out       (out_sp_out),
    .out_neg_flag     (out_neg_flag),
    .out_zero_flag    (out_zero_flag),
    .out_carry_flag   (out_carry_flag),
    .out_ovf_flag     (out_ovf_flag),
    .out_dec_flag     (out_dec_flag),
    .out_irq_mask_flag(out_irq_mask_flag)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // next architectural state after one command
  function automatic arch_t apply_command(arch_t s, logic [CmdW-1:0] cmd,
                                          logic [DataW-1:0] opnd);
    logic [DataW-1:0] addend;
    logic [DataW:0]   sum;
    arch_t            t;
    t = s;
    // subtract is add of the inverted operand, carry set means no borrow
    addend = (cmd == CMD_SBC) ? ~opnd : opnd;
    sum = {1'b0, s.acc} + {1'b0, addend} + {{DataW{1'b0}}, s.c};
    case (cmd)
      CMD_ADC, CMD_SBC: begin
        t.acc = sum[DataW-1:0];
        t.c   = sum[DataW];
        // same sign in, other sign out
        t.v   = ~(s.acc[DataW-1] ^ addend[DataW-1]) & (s.acc[DataW-1] ^ sum[DataW-1]);
      end
      CMD_AND: t.acc = s.acc & opnd;
      CMD_EOR: t.acc = s.acc ^ opnd;
      CMD_ORA: t.acc = s.acc | opnd;
      // rotates go through the carry
      CMD_ROL: begin
        t.acc = {s.acc[DataW-2:0], s.c};
        t.c   = s.acc[DataW-1];
      end
      CMD_ROR: begin
        t.acc = {s.c, s.acc[DataW-1:1]};
        t.c   = s.acc[0];
      end
      CMD_SEC: t.c = 1'b1;
      CMD_CLC: t.c = 1'b0;
      CMD_SED: t.d = 1'b1;
      CMD_CLD: t.d = 1'b0;
      CMD_SEI: t.i = 1'b1;
      CMD_CLI: t.i = 1'b0;
      CMD_TAX: t.x   = s.acc;
      CMD_TAY: t.y   = s.acc;
      CMD_TXA: t.acc = s.x;
      CMD_TYA: t.acc = s.y;
      CMD_TSX: t.x   = s.sp;
      CMD_TXS: t.sp  = s.x;
      default: ;
    endcase
    // n and z follow whichever register the command wrote, txs leaves them
    case (cmd)
      CMD_ADC, CMD_SBC, CMD_AND, CMD_EOR, CMD_ORA, CMD_ROL, CMD_ROR, CMD_TXA,
      CMD_TYA: begin
        t.n = t.acc[DataW-1];
        t.z = (t.acc == '0);
      end
      CMD_TAX, CMD_TSX: begin
        t.n = t.x[DataW-1];
        t.z = (t.x == '0);
      end
      CMD_TAY: begin
        t.n = t.y[DataW-1];
        t.z = (t.y == '0);
      end
      default: ;
    endcase
    return t;
  endfunction

  // offer one command beat after a random gap, predict it once accepted
  task automatic issue_command(input logic [CmdW-1:0] cmd, input logic [DataW-1:0] opnd);
    int unsigned gap;
    gap = tx_no_idle ? 0 : $urandom_range(MaxGap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_operand <= opnd;
    do @(posedge clk); while (!in_ready);
    cpu_state = apply_command(cpu_state, cmd, opnd);
    pending_snapshots.push_back(cpu_state);
  endtask

  // drop valid and hold the input side until every owed snapshot has come back
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_snapshots.size() != 0);
  endtask

  function automatic logic [CmdW-1:0] random_command();
    // a few undecoded codes mixed in, they must leave the state alone
    if ($urandom_range(19) == 0) return CmdW'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
    return CmdW'($urandom_range(CMD_TXS, CMD_ADC));
  endfunction

  function automatic logic [DataW-1:0] random_operand();
    // bias toward the sign and carry boundaries
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hff;
      2:       return 8'h80;
      3:       return 8'h7f;
      default: return DataW'($urandom_range(255));
    endcase
  endfunction

  // operand extremes, every command, carry and overflow corners, undecoded codes
  task automatic test_directed();
    issue_command(CMD_ADC, 8'h00);        // zero result with carry clear
    issue_command(CMD_ADC, 8'h7f);
    issue_command(CMD_ADC, 8'h01);        // positive overflow into the sign bit
    issue_command(CMD_ADC, 8'hff);        // carry out and negative overflow
    issue_command(CMD_ADC, 8'h80);        // carry in counted, wraps to zero
    issue_command(CMD_SBC, 8'h00);        // carry set, no borrow
    issue_command(CMD_CLC, 8'h5a);        // operand ignored
    issue_command(CMD_SBC, 8'h00);        // borrow from zero
    issue_command(CMD_ROL, 8'hff);        // old bit 7 into carry
    issue_command(CMD_ROR, 8'h00);        // old carry into bit 7
    issue_command(CMD_SEC, 8'h00);
    issue_command(CMD_ROR, 8'h00);
    issue_command(CMD_ROL, 8'h00);
    issue_command(CMD_AND, 8'h00);
    issue_command(CMD_ORA, 8'ha5);
    issue_command(CMD_EOR, 8'hff);
    issue_command(CMD_SED, 8'h00);
    issue_command(CMD_SEI, 8'h00);
    issue_command(CMD_CLD, 8'h00);
    issue_command(CMD_CLI, 8'h00);
    issue_command(CMD_TAX, 8'h00);
    issue_command(CMD_TXS, 8'h00);        // no flag change
    issue_command(CMD_AND, 8'h00);
    issue_command(CMD_TAY, 8'h00);        // zero copied into y
    issue_command(CMD_TSX, 8'h00);
    issue_command(CMD_TXA, 8'h00);
    issue_command(CMD_TYA, 8'h00);
    issue_command(CMD_UNUSED_LO, 8'hff);
    issue_command(CMD_UNUSED_HI, 8'hff);
  endtask

  // sink holds off while the source streams, the unit must fill and stall
  task automatic test_backpressure();
    int unsigned k;
    wait_for_drain();
    tx_no_idle     = 1'b1;
    rx_hold_cycles = 80;
    for (k = 0; k < 24; k++) issue_command(random_command(), random_operand());
    tx_no_idle = 1'b0;
    wait_for_drain();
  endtask

  // random traffic in segments with different idle patterns on each side
  task automatic test_random();
    int unsigned k;
    int unsigned mode;
    for (k = 0; k < RandomItems; k++) begin
      if (k % 100 == 0) begin
        mode       = $urandom_range(3);
        tx_no_idle = mode[0];
        rx_no_idle = mode[1];
      end
      // source pauses now and then until everything has come back
      if (k % 150 == 75) wait_for_drain();
      issue_command(random_command(), random_operand());
    end
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
  endtask

  // main sequence
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_command     = CMD_ADC;
    in_operand     = '0;
    cpu_state      = '0;
    error_count    = 0;
    tx_no_idle     = 1'b0;
    rx_no_idle     = 1'b0;
    rx_hold_cycles = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_random();

    wait_for_drain();
    // anything arriving now is an extra beat
    repeat (SettleCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // result sink: random stall per beat, plus one long hold on request
  initial begin : result_sink
    int unsigned stall;
    out_ready = 1'b0;
    forever begin
      stall          = (rx_no_idle ? 0 : $urandom_range(MaxGap)) + rx_hold_cycles;
      rx_hold_cycles = 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid && rx_hold_cycles == 0);
    end
  end

  task automatic check_field(input string field, input logic [DataW-1:0] expected,
                             input logic [DataW-1:0] actual);
    if (expected !== actual) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $realtime, field, expected,
               actual);
      error_count++;
    end
  endtask

  task automatic check_flag(input string field, input logic expected, input logic actual);
    if (expected !== actual) begin
      $display("%0t: %s mismatch, expected %0b actual %0b", $realtime, field, expected,
               actual);
      error_count++;
    end
  endtask

  // compare every output beat against the oldest predicted snapshot
  always @(posedge clk) begin
    arch_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_snapshots.size() == 0) begin
        $display("%0t: output beat with nothing outstanding, expected none actual acc %0h",
                 $realtime, out_acc_out);
        error_count++;
      end else begin
        want = pending_snapshots.pop_front();
        check_field("acc", want.acc, out_acc_out);
        check_field("x", want.x, out_x_out);
        check_field("y", want.y, out_y_out);
        check_field("sp", want.sp, out_sp_out);
        check_flag("n", want.n, out_neg_flag);
        check_flag("z", want.z, out_zero_flag);
        check_flag("c", want.c, out_carry_flag);
        check_flag("v", want.v, out_ovf_flag);
        check_flag("d", want.d, out_dec_flag);
        check_flag("i", want.i, out_irq_mask_flag);
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial quiet_cycles = 0;

endmodule
